FILE: sv/uctseq_pkg.sv
// Shared types and codes for the USB control transfer sequencer.
// Used by the front, queue, back and top-level files; depends on nothing.
`timescale 1ns / 1ps

package uctseq_pkg;

    // Command opcodes as they arrive in s_axis_tuser.
    localparam logic [2:0] OP_RESET      = 3'd0;
    localparam logic [2:0] OP_BEGIN_SET  = 3'd1;
    localparam logic [2:0] OP_DATA_OUT   = 3'd2;
    localparam logic [2:0] OP_DATA_IN    = 3'd3;
    localparam logic [2:0] OP_STATUS_IN  = 3'd4;
    localparam logic [2:0] OP_STATUS_OUT = 3'd5;
    localparam logic [2:0] OP_IRQ        = 3'd6;
    localparam logic [2:0] OP_NOP        = 3'd7;

    // Work kinds after classification, with interrupt priority already resolved.
    localparam logic [3:0] K_NOP        = 4'd0;
    localparam logic [3:0] K_RESET      = 4'd1;
    localparam logic [3:0] K_SETUP      = 4'd2;
    localparam logic [3:0] K_DATA_OUT   = 4'd3;
    localparam logic [3:0] K_DATA_IN    = 4'd4;
    localparam logic [3:0] K_STATUS_IN  = 4'd5;
    localparam logic [3:0] K_STATUS_OUT = 4'd6;
    localparam logic [3:0] K_IRQ_SETUP  = 4'd7;
    localparam logic [3:0] K_IRQ_OUT    = 4'd8;
    localparam logic [3:0] K_IRQ_IN     = 4'd9;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SETUP  = 2'd1;
    localparam logic [1:0] ST_DATA   = 2'd2;
    localparam logic [1:0] ST_STATUS = 2'd3;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_OUT  = 2'd1;
    localparam logic [1:0] DIR_IN   = 2'd2;

    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_SETUP    = 2'd1;
    localparam logic [1:0] EV_OUT_DONE = 2'd2;
    localparam logic [1:0] EV_XFER_END = 2'd3;

    localparam logic [1:0] IRQ_NONE  = 2'd0;
    localparam logic [1:0] IRQ_SETUP = 2'd1;
    localparam logic [1:0] IRQ_OUT   = 2'd2;
    localparam logic [1:0] IRQ_IN    = 2'd3;

    localparam logic [1:0] ACT_NONE       = 2'd0;
    localparam logic [1:0] ACT_ARM_IN     = 2'd1;
    localparam logic [1:0] ACT_ARM_OUT    = 2'd2;
    localparam logic [1:0] ACT_READ_SETUP = 2'd3;

    localparam logic [2:0] FLT_OK        = 3'd0;
    localparam logic [2:0] FLT_BAD_STAGE = 3'd1;
    localparam logic [2:0] FLT_ZERO_LEN  = 3'd2;
    localparam logic [2:0] FLT_ACTIVE    = 3'd3;
    localparam logic [2:0] FLT_BAD_DIR   = 3'd4;
    localparam logic [2:0] FLT_BAD_SIZE  = 3'd5;
    localparam logic [2:0] FLT_OVERRUN   = 3'd6;

    localparam logic [6:0] SETUP_PKT_LEN = 7'd8;
    localparam logic [6:0] MPS_RESET     = 7'd64;

    localparam int QUEUE_DEPTH = 2;

    // One classified command as it waits in the queue.
    typedef struct packed {
        logic [3:0]  kind;
        logic [1:0]  irq;
        logic [15:0] length;
        logic        zlp;
        logic [6:0]  rx_size;
    } t_cmd;

    // Result word; the last member lands in the lowest bits.
    typedef struct packed {
        logic        busy;
        logic [2:0]  fault;
        logic        copy;
        logic [15:0] offset;
        logic [6:0]  plen;
        logic [1:0]  action;
        logic [1:0]  irq;
    } t_result;

endpackage

FILE: sv/uctseq_front.sv
// Front end: unpacks an incoming word and classifies it into a command kind.
// Depends on uctseq_pkg.
`timescale 1ns / 1ps

module uctseq_front import uctseq_pkg::*; (
    input  logic [31:0] i_tdata,
    input  logic [2:0]  i_tuser,
    output t_cmd        o_cmd
);

    logic isetup, iout, iin;

    assign isetup = i_tdata[17];
    assign iout   = i_tdata[18];
    assign iin    = i_tdata[19];

    always_comb begin
        o_cmd.length  = i_tdata[15:0];
        o_cmd.zlp     = i_tdata[16];
        o_cmd.rx_size = i_tdata[26:20];
        o_cmd.kind    = K_NOP;
        o_cmd.irq     = IRQ_NONE;
        unique case (i_tuser)
            OP_RESET:      o_cmd.kind = K_RESET;
            OP_BEGIN_SET:  o_cmd.kind = K_SETUP;
            OP_DATA_OUT:   o_cmd.kind = K_DATA_OUT;
            OP_DATA_IN:    o_cmd.kind = K_DATA_IN;
            OP_STATUS_IN:  o_cmd.kind = K_STATUS_IN;
            OP_STATUS_OUT: o_cmd.kind = K_STATUS_OUT;
            OP_IRQ: begin
                // Setup beats out, out beats in.
                priority if (isetup) begin
                    o_cmd.kind = K_IRQ_SETUP;
                    o_cmd.irq  = IRQ_SETUP;
                end else if (iout) begin
                    o_cmd.kind = K_IRQ_OUT;
                    o_cmd.irq  = IRQ_OUT;
                end else if (iin) begin
                    o_cmd.kind = K_IRQ_IN;
                    o_cmd.irq  = IRQ_IN;
                end else begin
                    o_cmd.kind = K_NOP;
                end
            end
            OP_NOP:        o_cmd.kind = K_NOP;
            default:       o_cmd.kind = K_NOP;
        endcase
    end

endmodule

FILE: sv/uctseq_queue.sv
// Short command queue between the front end and the back end.
// Depends on uctseq_pkg for the command type and depth.
`timescale 1ns / 1ps

module uctseq_queue import uctseq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    output logic o_wr_ready,
    input  t_cmd i_wr_data,
    output logic o_rd_valid,
    input  logic i_rd_pop,
    output t_cmd o_rd_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push, pop;

    assign o_wr_ready = (r_count != FULL_CNT);
    assign o_rd_valid = (r_count != '0);
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = i_rd_pop && o_rd_valid;
    assign o_rd_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: sv/uctseq_back.sv
// Back end: holds the transfer state, executes one command per cycle unless
// the result word is stalled, and registers it. Depends on uctseq_pkg.
`timescale 1ns / 1ps

module uctseq_back import uctseq_pkg::*; #(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_valid,
    input  logic [6:0] i_cfg_data,
    input  logic    i_q_valid,
    input  t_cmd    i_cmd,
    output logic    o_q_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output logic [1:0] o_event,
    output t_result o_result
);

    localparam int LW = LENGTH_WIDTH;

    logic [1:0]    r_stage, n_stage;
    logic [1:0]    r_dir, n_dir;
    logic          r_in_active, n_in_active;
    logic [LW-1:0] r_in_offset, n_in_offset;
    logic [LW-1:0] r_in_total, n_in_total;
    logic [6:0]    r_in_flight, n_in_flight;
    logic          r_zlp_pending, n_zlp_pending;
    logic          r_out_active, n_out_active;
    logic [LW-1:0] r_out_offset, n_out_offset;
    logic [LW-1:0] r_out_expected, n_out_expected;
    logic [6:0]    r_mps;

    logic          r_valid;
    logic [1:0]    r_event;
    t_result       r_result;

    logic [LW-1:0] len_w, rx_w, in_next_off, out_sum, out_room;
    logic [LW-1:0] send_off, send_tot, send_rem, send_len;
    logic          out_overrun, do_clear;
    logic [1:0]    ev, act;
    logic [6:0]    plen;
    logic [LW-1:0] boff;
    logic          copy;
    logic [2:0]    flt;

    assign o_q_pop  = i_q_valid && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_event  = r_event;
    assign o_result = r_result;

    assign len_w       = LW'(i_cmd.length);
    assign rx_w        = LW'(i_cmd.rx_size);
    assign in_next_off = r_in_offset + LW'(r_in_flight);
    assign out_sum     = r_out_offset + rx_w;
    assign out_room    = r_out_expected - r_out_offset;
    assign out_overrun = (r_out_offset > r_out_expected) || (rx_w > out_room);

    // Next IN packet: a new data stage starts at offset zero of the new length.
    assign send_off = (i_cmd.kind == K_DATA_IN) ? '0 : in_next_off;
    assign send_tot = (i_cmd.kind == K_DATA_IN) ? len_w : r_in_total;
    assign send_rem = send_tot - send_off;
    assign send_len = (send_rem < LW'(r_mps)) ? send_rem : LW'(r_mps);

    always_comb begin
        n_stage        = r_stage;
        n_dir          = r_dir;
        n_in_active    = r_in_active;
        n_in_offset    = r_in_offset;
        n_in_total     = r_in_total;
        n_in_flight    = r_in_flight;
        n_zlp_pending  = r_zlp_pending;
        n_out_active   = r_out_active;
        n_out_offset   = r_out_offset;
        n_out_expected = r_out_expected;
        do_clear = 1'b0;
        ev   = EV_NONE;
        act  = ACT_NONE;
        plen = '0;
        boff = '0;
        copy = 1'b0;
        flt  = FLT_OK;

        unique case (i_cmd.kind)
            K_RESET: begin
                do_clear = 1'b1;
                n_stage  = ST_IDLE;
                n_dir    = DIR_NONE;
            end
            K_SETUP: begin
                do_clear = 1'b1;
                n_stage  = ST_SETUP;
                n_dir    = DIR_NONE;
                act      = ACT_READ_SETUP;
                plen     = SETUP_PKT_LEN;
                copy     = 1'b1;
            end
            K_DATA_OUT: begin
                priority if (r_stage != ST_SETUP) begin
                    flt = FLT_BAD_STAGE;
                end else if (len_w == '0) begin
                    flt = FLT_ZERO_LEN;
                end else if (r_out_active) begin
                    flt = FLT_ACTIVE;
                end else begin
                    n_out_offset   = '0;
                    n_out_expected = len_w;
                    n_out_active   = 1'b1;
                    n_dir          = DIR_OUT;
                    n_stage        = ST_DATA;
                    act            = ACT_ARM_OUT;
                end
            end
            K_DATA_IN: begin
                priority if (r_stage != ST_SETUP) begin
                    flt = FLT_BAD_STAGE;
                end else if (len_w == '0) begin
                    flt = FLT_ZERO_LEN;
                end else if (r_in_active) begin
                    flt = FLT_ACTIVE;
                end else begin
                    n_in_offset   = '0;
                    n_in_total    = len_w;
                    n_in_active   = 1'b1;
                    n_zlp_pending = i_cmd.zlp;
                    n_dir         = DIR_IN;
                    n_stage       = ST_DATA;
                    n_in_flight   = send_len[6:0];
                    act           = ACT_ARM_IN;
                    plen          = send_len[6:0];
                    copy          = 1'b1;
                end
            end
            K_STATUS_IN: begin
                do_clear = 1'b1;
                n_stage  = ST_STATUS;
                n_dir    = DIR_IN;
                act      = ACT_ARM_IN;
            end
            K_STATUS_OUT: begin
                do_clear = 1'b1;
                n_stage  = ST_STATUS;
                n_dir    = DIR_OUT;
                act      = ACT_ARM_OUT;
            end
            K_IRQ_SETUP: begin
                ev = EV_SETUP;
            end
            K_IRQ_OUT: begin
                priority if (r_stage == ST_STATUS) begin
                    priority if (r_dir != DIR_OUT) begin
                        flt = FLT_BAD_DIR;
                    end else if (i_cmd.rx_size != '0) begin
                        flt = FLT_BAD_SIZE;
                    end else begin
                        do_clear = 1'b1;
                        n_stage  = ST_IDLE;
                        n_dir    = DIR_NONE;
                        ev       = EV_XFER_END;
                    end
                end else if (r_stage != ST_DATA) begin
                    flt = FLT_BAD_STAGE;
                end else if (r_dir != DIR_OUT) begin
                    flt = FLT_BAD_DIR;
                end else if (!r_out_active) begin
                    // Direction inactive: nothing to report.
                end else if (out_overrun) begin
                    flt = FLT_OVERRUN;
                end else begin
                    copy         = 1'b1;
                    plen         = i_cmd.rx_size;
                    boff         = r_out_offset;
                    n_out_offset = out_sum;
                    if (out_sum >= r_out_expected) begin
                        n_out_active = 1'b0;
                        ev           = EV_OUT_DONE;
                    end else begin
                        act = ACT_ARM_OUT;
                    end
                end
            end
            K_IRQ_IN: begin
                priority if (r_stage == ST_STATUS) begin
                    if (r_dir != DIR_IN) begin
                        flt = FLT_BAD_DIR;
                    end else begin
                        do_clear = 1'b1;
                        n_stage  = ST_IDLE;
                        n_dir    = DIR_NONE;
                        ev       = EV_XFER_END;
                    end
                end else if (r_stage != ST_DATA) begin
                    flt = FLT_BAD_STAGE;
                end else if (r_dir != DIR_IN) begin
                    flt = FLT_BAD_DIR;
                end else if (!r_in_active) begin
                    // Direction inactive: nothing to report.
                end else if (in_next_off < r_in_total) begin
                    n_in_offset = in_next_off;
                    n_in_flight = send_len[6:0];
                    act         = ACT_ARM_IN;
                    plen        = send_len[6:0];
                    boff        = in_next_off;
                    copy        = 1'b1;
                end else if (r_zlp_pending) begin
                    n_in_offset   = in_next_off;
                    n_in_flight   = '0;
                    n_zlp_pending = 1'b0;
                    act           = ACT_ARM_IN;
                end else begin
                    // All data sent: the host now sends the OUT status packet.
                    do_clear = 1'b1;
                    n_stage  = ST_STATUS;
                    n_dir    = DIR_OUT;
                    act      = ACT_ARM_OUT;
                end
            end
            default: begin
            end
        endcase

        if (do_clear) begin
            n_in_active    = 1'b0;
            n_zlp_pending  = 1'b0;
            n_out_active   = 1'b0;
            n_in_offset    = '0;
            n_in_total     = '0;
            n_in_flight    = '0;
            n_out_offset   = '0;
            n_out_expected = '0;
        end

        // A fault reports only the code, the examined interrupt and busy.
        if (flt != FLT_OK) begin
            n_stage        = r_stage;
            n_dir          = r_dir;
            n_in_active    = r_in_active;
            n_in_offset    = r_in_offset;
            n_in_total     = r_in_total;
            n_in_flight    = r_in_flight;
            n_zlp_pending  = r_zlp_pending;
            n_out_active   = r_out_active;
            n_out_offset   = r_out_offset;
            n_out_expected = r_out_expected;
            ev   = EV_NONE;
            act  = ACT_NONE;
            plen = '0;
            boff = '0;
            copy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mps <= MPS_RESET;
        end else if (i_cfg_valid) begin
            r_mps <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage        <= ST_IDLE;
            r_dir          <= DIR_NONE;
            r_in_active    <= 1'b0;
            r_in_offset    <= '0;
            r_in_total     <= '0;
            r_in_flight    <= '0;
            r_zlp_pending  <= 1'b0;
            r_out_active   <= 1'b0;
            r_out_offset   <= '0;
            r_out_expected <= '0;
            r_valid        <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_stage        <= n_stage;
                r_dir          <= n_dir;
                r_in_active    <= n_in_active;
                r_in_offset    <= n_in_offset;
                r_in_total     <= n_in_total;
                r_in_flight    <= n_in_flight;
                r_zlp_pending  <= n_zlp_pending;
                r_out_active   <= n_out_active;
                r_out_offset   <= n_out_offset;
                r_out_expected <= n_out_expected;
                r_valid        <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_event         <= ev;
            r_result.irq    <= i_cmd.irq;
            r_result.action <= act;
            r_result.plen   <= plen;
            r_result.offset <= 16'(boff);
            r_result.copy   <= copy;
            r_result.fault  <= flt;
            r_result.busy   <= (n_stage != ST_IDLE);
        end
    end

endmodule

FILE: sv/usb_control_transfer_sequencer.sv
// USB endpoint-zero control transfer sequencer, top level.
// Ties together uctseq_front, uctseq_queue and uctseq_back; uses uctseq_pkg.
`timescale 1ns / 1ps

// Every accepted word yields exactly one result word. The block takes one word
// per cycle and delivers one result per cycle when the output side keeps
// m_axis_tready high; a word's result passes through the two-entry command
// queue and then the back end's result register before it is offered on the
// master side. The back end updates the whole transfer state with each command
// it pops, which sets the one-word-per-cycle rate. The max_packet_size
// register is written through the cfg channel, which is always ready, and
// should only be written while no words are in flight.
module usb_control_transfer_sequencer import uctseq_pkg::*; #(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // data_length[15:0], send_zlp[16], irq_setup[17], irq_out[18], irq_in[19],
    // received_size[26:20], zero fill[31:27]
    input  logic [31:0] s_axis_tdata,
    // opcode[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // irq_handled[1:0], action[3:2], packet_length[10:4], buffer_offset[26:11],
    // copy_data[27], fault[30:28], busy_res[31]
    output logic [31:0] m_axis_tdata,
    // event_code[1:0]
    output logic [1:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);

    t_cmd    front_cmd, queue_cmd;
    logic    queue_valid, queue_pop;
    t_result result;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = result;

    uctseq_front u_front (
        .i_tdata (s_axis_tdata),
        .i_tuser (s_axis_tuser),
        .o_cmd   (front_cmd)
    );

    uctseq_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (s_axis_tvalid),
        .o_wr_ready (s_axis_tready),
        .i_wr_data  (front_cmd),
        .o_rd_valid (queue_valid),
        .i_rd_pop   (queue_pop),
        .o_rd_data  (queue_cmd)
    );

    uctseq_back #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (queue_valid),
        .i_cmd       (queue_cmd),
        .o_q_pop     (queue_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_event     (m_axis_tuser),
        .o_result    (result)
    );

endmodule

FILE: sv/uctseq_checker.sv
// Port-level checker for the USB control transfer sequencer, bound to the top.
// Depends on uctseq_pkg for the result codes.
`timescale 1ns / 1ps

module uctseq_checker import uctseq_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A result word that is not taken stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // A fault suppresses the event, the endpoint action and any copy.
    a_fault_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[30:28] != FLT_OK) |->
            (m_axis_tuser == EV_NONE) && (m_axis_tdata[3:2] == ACT_NONE)
            && !m_axis_tdata[27] && (m_axis_tdata[10:4] == 7'd0))
        else $error("faulted word carries an action");

    // Without a copy there is no buffer position.
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[27] |-> (m_axis_tdata[26:11] == 16'd0))
        else $error("buffer offset without copy");

    // Reading the setup packet always copies eight bytes and leaves the block busy.
    a_read_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[3:2] == ACT_READ_SETUP) |->
            (m_axis_tdata[10:4] == SETUP_PKT_LEN) && m_axis_tdata[27]
            && m_axis_tdata[31])
        else $error("malformed read setup word");

    // The setup event only comes from the setup interrupt.
    a_setup_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == EV_SETUP) |->
            (m_axis_tdata[1:0] == IRQ_SETUP))
        else $error("setup event without setup interrupt");

endmodule

bind usb_control_transfer_sequencer uctseq_checker u_uctseq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/tb_top.sv
// Self-checking testbench for usb_control_transfer_sequencer: directed words, then
// random transfers and stray words, checked against an in-bench transfer predictor.
// Depends on uctseq_pkg and usb_control_transfer_sequencer.
`timescale 1ns / 1ps

module tb_top;
    import uctseq_pkg::*;

    // One command or interrupt word as it enters the slave side.
    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] len;
        logic        zlp;
        logic        irq_setup;
        logic        irq_out;
        logic        irq_in;
        logic [6:0]  rx;
    } ctl_word_t;

    // One result word as it leaves the master side.
    typedef struct packed {
        logic [1:0]  event_code;
        logic [1:0]  irq;
        logic [1:0]  action;
        logic [6:0]  plen;
        logic [15:0] boff;
        logic        copy;
        logic [2:0]  fault;
        logic        busy;
    } xfer_result_t;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = OP_NOP;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data = MPS_RESET;

    usb_control_transfer_sequencer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    ctl_word_t    pending_words[$];
    xfer_result_t expected_results[$];
    ctl_word_t    in_word = '0;
    bit           word_taken = 1'b0;
    bit           result_taken = 1'b0;
    bit           calm = 1'b0;
    int           calm_left = 20;
    int           send_gap = 0;
    int           recv_stall = 0;
    int           words_queued = 0;
    int           words_sent = 0;
    int           results_checked = 0;
    int           transfers_done = 0;
    int           faults_seen = 0;
    int           errors = 0;

    // Predicted transfer state and the packet size register.
    logic [1:0]   p_stage = ST_IDLE;
    logic [1:0]   p_dir = DIR_NONE;
    logic         p_in_act = 1'b0;
    logic         p_zlp_pend = 1'b0;
    logic         p_out_act = 1'b0;
    logic [15:0]  p_in_off = '0;
    logic [15:0]  p_in_total = '0;
    logic [6:0]   p_in_flight = '0;
    logic [15:0]  p_out_off = '0;
    logic [15:0]  p_out_exp = '0;
    logic [6:0]   p_mps = MPS_RESET;
    xfer_result_t nx;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("Timeout: %0d results still expected", expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    task clear_transfer_state();
        p_stage     = ST_IDLE;
        p_dir       = DIR_NONE;
        p_in_act    = 1'b0;
        p_zlp_pend  = 1'b0;
        p_out_act   = 1'b0;
        p_in_off    = '0;
        p_in_total  = '0;
        p_in_flight = '0;
        p_out_off   = '0;
        p_out_exp   = '0;
    endtask

    task enter_status_stage(input logic [1:0] dir);
        clear_transfer_state();
        p_stage   = ST_STATUS;
        p_dir     = dir;
        nx.action = (dir == DIR_IN) ? ACT_ARM_IN : ACT_ARM_OUT;
        nx.plen   = '0;
    endtask

    task arm_next_in_packet();
        logic [15:0] rem;
        if (p_in_act) begin
            if (p_in_off < p_in_total) begin
                rem = p_in_total - p_in_off;
                p_in_flight = (rem < {9'd0, p_mps}) ? rem[6:0] : p_mps;
                nx.action = ACT_ARM_IN;
                nx.plen   = p_in_flight;
                nx.boff   = p_in_off;
                nx.copy   = 1'b1;
            end else if (p_zlp_pend) begin
                // Buffer fully sent; the zero length packet closes the stage.
                p_in_flight = '0;
                p_zlp_pend  = 1'b0;
                nx.action   = ACT_ARM_IN;
                nx.plen     = '0;
            end
        end
    endtask

    task serve_out_irq(input logic [6:0] rx);
        if (p_stage == ST_STATUS) begin
            if (p_dir != DIR_OUT) nx.fault = FLT_BAD_DIR;
            else if (rx != 0) nx.fault = FLT_BAD_SIZE;
            else begin
                clear_transfer_state();
                nx.event_code = EV_XFER_END;
            end
        end else if (p_stage != ST_DATA) begin
            nx.fault = FLT_BAD_STAGE;
        end else if (p_dir != DIR_OUT) begin
            nx.fault = FLT_BAD_DIR;
        end else if (p_out_act) begin
            if (p_out_off > p_out_exp || {9'd0, rx} > p_out_exp - p_out_off) begin
                nx.fault = FLT_OVERRUN;
            end else begin
                nx.copy   = 1'b1;
                nx.plen   = rx;
                nx.boff   = p_out_off;
                p_out_off = p_out_off + {9'd0, rx};
                if (p_out_off >= p_out_exp) begin
                    p_out_act     = 1'b0;
                    nx.event_code = EV_OUT_DONE;
                end else begin
                    nx.action = ACT_ARM_OUT;
                end
            end
        end
    endtask

    task serve_in_irq();
        if (p_stage == ST_STATUS) begin
            if (p_dir != DIR_IN) nx.fault = FLT_BAD_DIR;
            else clear_transfer_state();
        end else if (p_stage != ST_DATA) begin
            nx.fault = FLT_BAD_STAGE;
        end else if (p_dir != DIR_IN) begin
            nx.fault = FLT_BAD_DIR;
        end else if (p_in_act) begin
            p_in_off    = p_in_off + {9'd0, p_in_flight};
            p_in_flight = '0;
            if (p_in_off < p_in_total || p_zlp_pend) arm_next_in_packet();
            else enter_status_stage(DIR_OUT);
        end
    endtask

    task predict_control_word(input ctl_word_t w);
        nx = '0;
        case (w.op)
            OP_RESET: clear_transfer_state();
            OP_BEGIN_SET: begin
                clear_transfer_state();
                p_stage   = ST_SETUP;
                nx.action = ACT_READ_SETUP;
                nx.plen   = SETUP_PKT_LEN;
                nx.copy   = 1'b1;
            end
            OP_DATA_OUT: begin
                if (p_stage != ST_SETUP) nx.fault = FLT_BAD_STAGE;
                else if (w.len == 0) nx.fault = FLT_ZERO_LEN;
                else if (p_out_act) nx.fault = FLT_ACTIVE;
                else begin
                    p_out_off = '0;
                    p_out_exp = w.len;
                    p_out_act = 1'b1;
                    p_dir     = DIR_OUT;
                    p_stage   = ST_DATA;
                    nx.action = ACT_ARM_OUT;
                end
            end
            OP_DATA_IN: begin
                if (p_stage != ST_SETUP) nx.fault = FLT_BAD_STAGE;
                else if (w.len == 0) nx.fault = FLT_ZERO_LEN;
                else if (p_in_act) nx.fault = FLT_ACTIVE;
                else begin
                    p_in_off    = '0;
                    p_in_total  = w.len;
                    p_in_flight = '0;
                    p_in_act    = 1'b1;
                    p_zlp_pend  = w.zlp;
                    p_dir       = DIR_IN;
                    p_stage     = ST_DATA;
                    arm_next_in_packet();
                end
            end
            OP_STATUS_IN:  enter_status_stage(DIR_IN);
            OP_STATUS_OUT: enter_status_stage(DIR_OUT);
            OP_IRQ: begin
                if (w.irq_setup) begin
                    nx.irq        = IRQ_SETUP;
                    nx.event_code = EV_SETUP;
                end else if (w.irq_out) begin
                    nx.irq = IRQ_OUT;
                    serve_out_irq(w.rx);
                end else if (w.irq_in) begin
                    nx.irq = IRQ_IN;
                    serve_in_irq();
                    if (nx.fault == FLT_OK && p_stage == ST_IDLE) nx.event_code = EV_XFER_END;
                end
            end
            default: ;
        endcase
        // A fault keeps only the interrupt that was looked at.
        if (nx.fault != FLT_OK) begin
            nx.event_code = EV_NONE;
            nx.action     = ACT_NONE;
            nx.plen       = '0;
            nx.boff       = '0;
            nx.copy       = 1'b0;
        end
        nx.busy = (p_stage != ST_IDLE);
        expected_results.push_back(nx);
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_control_word(in_word);
            word_taken = 1'b1;
            words_sent++;
        end
    end

    always @(negedge i_clk) begin : drive_words
        logic hold;
        hold = s_axis_tvalid && !word_taken;
        if (word_taken) begin
            word_taken = 1'b0;
            // Alternate stretches with and without idle cycles on both sides.
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(10, 60);
            end else begin
                calm_left--;
            end
            send_gap = calm ? 0 : $urandom_range(0, 4);
        end
        if (!hold && i_rst_n) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_words.size() > 0) begin
                in_word = pending_words.pop_front();
                hold    = 1'b1;
            end
        end
        s_axis_tvalid <= hold;
        s_axis_tdata  <= {5'd0, in_word.rx, in_word.irq_in, in_word.irq_out,
                          in_word.irq_setup, in_word.zlp, in_word.len};
        s_axis_tuser  <= in_word.op;
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin : check_results
        xfer_result_t got;
        xfer_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.event_code = m_axis_tuser;
            got.irq        = m_axis_tdata[1:0];
            got.action     = m_axis_tdata[3:2];
            got.plen       = m_axis_tdata[10:4];
            got.boff       = m_axis_tdata[26:11];
            got.copy       = m_axis_tdata[27];
            got.fault      = m_axis_tdata[30:28];
            got.busy       = m_axis_tdata[31];
            result_taken   = 1'b1;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result word with nothing expected: %p", $realtime, got);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.event_code == EV_XFER_END) transfers_done++;
                if (want.fault != FLT_OK) faults_seen++;
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result %0d mismatch\n  expected %p\n  actual   %p",
                                 $realtime, results_checked, want, got);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (result_taken) begin
            result_taken = 1'b0;
            recv_stall   = calm ? 0 : $urandom_range(0, 4);
        end
        if (recv_stall > 0) begin
            recv_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic logic rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [15:0] rlen();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [6:0] rrx();
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic void queue_word(input logic [2:0] op, input logic [15:0] len,
                                       input logic zlp, input logic is, input logic io,
                                       input logic ii, input logic [6:0] rx);
        ctl_word_t w;
        w.op = op; w.len = len; w.zlp = zlp;
        w.irq_setup = is; w.irq_out = io; w.irq_in = ii; w.rx = rx;
        pending_words.push_back(w);
        words_queued++;
    endfunction

    // A well-formed control transfer with random content, ending now and then
    // in an abort or a bad status handshake.
    task automatic gen_control_transfer(input int mps);
        int kind, len_total, left, rx, n, k;
        logic zlp;
        kind = $urandom_range(0, 5);
        queue_word(OP_BEGIN_SET, rlen(), rbit(), rbit(), rbit(), rbit(), rrx());
        queue_word(OP_IRQ, rlen(), rbit(), 1'b1, rbit(), rbit(), rrx());
        if (kind <= 1) begin
            len_total = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 65535)
                                                     : $urandom_range(1, 3 * mps + 5);
            queue_word(OP_DATA_OUT, 16'(len_total), rbit(), 1'b0, rbit(), rbit(), rrx());
            left = len_total;
            k = 0;
            while (left > 0 && k < 12) begin
                if ($urandom_range(0, 7) == 0) begin
                    rx = $urandom_range(0, 127);
                end else begin
                    rx = (left < mps) ? left : mps;
                    if ($urandom_range(0, 3) == 0) rx = $urandom_range(0, rx);
                end
                queue_word(OP_IRQ, rlen(), rbit(), 1'b0, 1'b1, rbit(), 7'(rx));
                if (rx <= left) left -= rx;
                k++;
            end
            if ($urandom_range(0, 5) == 0) begin
                queue_word(OP_RESET, rlen(), rbit(), rbit(), rbit(), rbit(), rrx());
            end else begin
                queue_word(OP_STATUS_IN, rlen(), rbit(), rbit(), rbit(), rbit(), rrx());
                queue_word(OP_IRQ, rlen(), rbit(), 1'b0, 1'b0, 1'b1, rrx());
            end
        end else if (kind <= 3) begin
            if (mps > 0 && $urandom_range(0, 5) == 0) len_total = mps * $urandom_range(1, 3);
            else if ($urandom_range(0, 24) == 0) len_total = $urandom_range(1, 65535);
            else len_total = $urandom_range(1, 3 * mps + 5);
            zlp = rbit();
            if (mps == 0 || len_total > 4 * mps) n = $urandom_range(1, 4);
            else n = (len_total + mps - 1) / mps + zlp;
            queue_word(OP_DATA_IN, 16'(len_total), zlp, 1'b0, rbit(), rbit(), rrx());
            repeat (n) queue_word(OP_IRQ, rlen(), rbit(), 1'b0, 1'b0, 1'b1, rrx());
            rx = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 127) : 0;
            queue_word(OP_IRQ, rlen(), rbit(), 1'b0, 1'b1, rbit(), 7'(rx));
            if (rx != 0) queue_word(OP_IRQ, rlen(), rbit(), 1'b0, 1'b1, rbit(), 7'd0);
        end else if (kind == 4) begin
            queue_word(OP_STATUS_IN, rlen(), rbit(), rbit(), rbit(), rbit(), rrx());
            queue_word(OP_IRQ, rlen(), rbit(), 1'b0, 1'b0, 1'b1, rrx());
        end else begin
            queue_word(OP_STATUS_OUT, rlen(), rbit(), rbit(), rbit(), rbit(), rrx());
            queue_word(OP_IRQ, rlen(), rbit(), 1'b0, 1'b1, rbit(), 7'd0);
        end
    endtask

    task automatic gen_phase(input int count, input int mps);
        int start;
        start = words_queued;
        while (words_queued - start < count) begin
            if ($urandom_range(0, 9) < 7)
                gen_control_transfer(mps);
            else
                repeat ($urandom_range(1, 3))
                    queue_word(3'($urandom_range(0, 7)), rlen(), rbit(), rbit(), rbit(),
                               rbit(), rrx());
        end
    endtask

    // Holds the stimulus back until every word has come out again.
    task automatic wait_drained();
        while (pending_words.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mps(input logic [6:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        p_mps = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : main_sequence
        int mps_steps[5];
        mps_steps = '{8, 127, 0, 23, 64};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset packet size.
        queue_word(OP_NOP, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 7'h7F);
        queue_word(OP_IRQ, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, 7'h7F);
        queue_word(OP_DATA_OUT, 16'd5, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
        queue_word(OP_IRQ, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1, 7'd0);
        queue_word(OP_BEGIN_SET, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
        queue_word(OP_IRQ, 16'd0, 1'b0, 1'b1, 1'b1, 1'b1, 7'd64);
        queue_word(OP_DATA_IN, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0, 7'd0);
        queue_word(OP_DATA_OUT, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, 7'd0);
        queue_word(OP_IRQ, 16'd0, 1'b0, 1'b0, 1'b1, 1'b1, 7'h7F);
        queue_word(OP_IRQ, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1, 7'd0);
        queue_word(OP_RESET, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 7'h7F);
        queue_word(OP_BEGIN_SET, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
        queue_word(OP_DATA_IN, 16'd128, 1'b1, 1'b0, 1'b0, 1'b0, 7'd0);
        queue_word(OP_IRQ, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1, 7'd0);
        queue_word(OP_IRQ, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1, 7'd0);
        queue_word(OP_IRQ, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1, 7'd0);
        queue_word(OP_IRQ, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1, 7'd0);
        queue_word(OP_IRQ, 16'd0, 1'b0, 1'b0, 1'b1, 1'b0, 7'd5);
        queue_word(OP_IRQ, 16'd0, 1'b0, 1'b0, 1'b1, 1'b0, 7'd0);
        queue_word(OP_BEGIN_SET, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
        queue_word(OP_DATA_OUT, 16'd10, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
        queue_word(OP_IRQ, 16'd0, 1'b0, 1'b0, 1'b1, 1'b0, 7'd20);
        queue_word(OP_IRQ, 16'd0, 1'b0, 1'b0, 1'b1, 1'b0, 7'd10);
        queue_word(OP_IRQ, 16'd0, 1'b0, 1'b0, 1'b1, 1'b0, 7'd0);
        queue_word(OP_STATUS_IN, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
        queue_word(OP_IRQ, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1, 7'd0);

        gen_phase(110, 64);
        wait_drained();
        foreach (mps_steps[i]) begin
            write_mps(7'(mps_steps[i]));
            gen_phase((mps_steps[i] == 0) ? 50 : 135, mps_steps[i]);
            wait_drained();
        end
        repeat (10) @(posedge i_clk);

        $display("Covered %0d words and %0d results: %0d completed transfers, %0d faults,",
                 words_sent, results_checked, transfers_done, faults_seen);
        $display("with max packet sizes 64, 8, 127, 0, 23 and 64 again; %0d mismatches.",
                 errors);
        if (errors == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
